// ===== hdl/lzss_decompressor_macros.svh =====
// ----------------------------------------------------------------------------
// lzss_decompressor_macros.svh
// Assertion macros for the LZSS decompressor. Checks are compiled out in
// synthesis builds.
// ----------------------------------------------------------------------------
`ifndef LZSS_DECOMPRESSOR_MACROS_SVH
`define LZSS_DECOMPRESSOR_MACROS_SVH

`ifndef SYNTHESIS

// Clocked check, held off while reset is asserted
`define LZD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs through reset
`define LZD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define LZD_ASSERT(lbl, clk, rst_n, prop, msg)

`define LZD_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== hdl/lzd_pkg.sv =====
// ----------------------------------------------------------------------------
// lzd_pkg
// Shared types and constants of the LZSS decompressor.
// ----------------------------------------------------------------------------
`default_nettype none

package lzd_pkg;

    // History window geometry
    localparam int WINDOW_SIZE = 4096;
    localparam int WIN_AW      = $clog2(WINDOW_SIZE);
    localparam int CNT_W       = WIN_AW + 1;

    // Match coding
    localparam int MIN_MATCH   = 3;
    localparam int LEN_W       = 5;

    // Configuration port
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 12;
    localparam logic [7:0]        FILL_RESET  = 8'h00;
    localparam logic [WIN_AW-1:0] START_RESET = 12'hFEE;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FILL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START = 2'd1;

    // Stream parser phase
    typedef enum logic [1:0] {
        PH_FLAG,
        PH_ITEM,
        PH_HIGH
    } t_phase;

    // Channel payloads
    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } t_out_item;

endpackage

`default_nettype wire

// ===== hdl/lzss_decompressor.sv =====
// ----------------------------------------------------------------------------
// lzss_decompressor
// LZSS decompressor with a 4096-byte history window held in one RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in) takes one compressed byte
//   per request; in_last marks the final byte of a stream. Output channel
//   (o_out_valid / i_out_ready / o_out) delivers decompressed bytes; out_last
//   is set on the last byte caused by one input request.
//   Per input request: a flag byte or first match byte only feeds the parser;
//   a literal passes the write stage (window write and output load); the
//   second match byte starts a copy of L bytes (3 to 18). The copy runs one
//   byte per cycle unless output stalls, bounded by the single read and
//   write port of the window RAM: each byte is read into a register and
//   written from the write stage, the just-written byte forwarded when a copy
//   overlaps its own output. A final byte restarts the stream once drained.
//   Reset and a register write restart the stream at once: the write
//   position goes to start_position and a fill counter marks the window as
//   empty, so unwritten entries read as fill_value with no clearing pass.
//   When the receiver stalls, the output register holds its byte and the
//   copy pauses with its pending read data held; input is refused until the
//   current request has produced all its bytes.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lzss_decompressor_macros.svh"

module lzss_decompressor
    import lzd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in_item              i_in,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out_item                  o_out,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Window RAM
    logic [7:0] mem [WINDOW_SIZE];

    // Configuration
    logic [7:0]        r_fill;
    logic [WIN_AW-1:0] r_start;

    // Window bookkeeping
    logic [WIN_AW-1:0] r_wpos;
    logic [CNT_W-1:0]  r_cnt;

    // Parser state
    t_phase      r_phase, n_phase;
    logic [7:0]  r_flags, n_flags;
    logic [2:0]  r_fidx,  n_fidx;
    logic [7:0]  r_low,   n_low;
    logic        r_rst_pend;

    // Copy engine
    logic [WIN_AW-1:0] r_src;
    logic [LEN_W-1:0]  r_rem;

    // Write stage
    logic        r_p1_valid;
    logic        r_p1_mem;
    logic [7:0]  r_p1_data;
    logic        r_p1_last;
    logic [7:0]  r_mem_q;

    // Output register
    logic        r_out_valid;
    t_out_item   r_out;

    logic              in_acc, out_ok, wr_en, issue, fwd, hit, drain_done;
    logic              dec_lit, dec_mhigh, cfg_hit;
    logic [7:0]        wr_byte;
    logic [WIN_AW-1:0] src_off;

    // Handshake and datapath control
    always_comb begin
        o_in_ready = !r_rst_pend && (r_rem == '0) && !r_p1_valid;
        in_acc     = i_in_valid && o_in_ready;
        out_ok     = !r_out_valid || i_out_ready;
        wr_en      = r_p1_valid && out_ok;
        wr_byte    = r_p1_mem ? r_mem_q : r_p1_data;
        issue      = (r_rem != '0) && (!r_p1_valid || wr_en);
        fwd        = wr_en && (r_src == r_wpos);
        src_off    = r_src - r_start;
        hit        = ({1'b0, src_off} < r_cnt);
        drain_done = r_rst_pend && (r_rem == '0) && !r_p1_valid;
        cfg_hit    = i_cfg_we && (i_cfg_index inside {CFG_FILL, CFG_START});
    end

    // Parser decode
    always_comb begin
        dec_lit   = in_acc && (r_phase == PH_ITEM) && r_flags[r_fidx];
        dec_mhigh = in_acc && (r_phase == PH_HIGH);
    end

    // Parser next state
    always_comb begin
        n_phase = r_phase;
        n_flags = r_flags;
        n_fidx  = r_fidx;
        n_low   = r_low;
        if (in_acc) begin
            case (r_phase)
                PH_FLAG: begin
                    n_flags = i_in.in_byte;
                    n_fidx  = '0;
                    n_phase = PH_ITEM;
                end
                PH_ITEM: begin
                    if (r_flags[r_fidx]) begin
                        n_fidx  = r_fidx + 3'd1;
                        n_phase = (r_fidx == 3'd7) ? PH_FLAG : PH_ITEM;
                    end else begin
                        n_low   = i_in.in_byte;
                        n_phase = PH_HIGH;
                    end
                end
                PH_HIGH: begin
                    n_fidx  = r_fidx + 3'd1;
                    n_phase = (r_fidx == 3'd7) ? PH_FLAG : PH_ITEM;
                end
                default: begin
                    n_phase = PH_FLAG;
                end
            endcase
            // End of stream drops parse state
            if (i_in.in_last) begin
                n_phase = PH_FLAG;
                n_flags = '0;
                n_fidx  = '0;
                n_low   = '0;
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= FILL_RESET;
            r_start     <= START_RESET;
            r_wpos      <= START_RESET;
            r_cnt       <= '0;
            r_phase     <= PH_FLAG;
            r_flags     <= '0;
            r_fidx      <= '0;
            r_low       <= '0;
            r_rst_pend  <= 1'b0;
            r_rem       <= '0;
            r_p1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (cfg_hit) begin
            // Register write restarts the stream with the new values
            if (i_cfg_index == CFG_FILL) begin
                r_fill <= i_cfg_data[7:0];
                r_wpos <= r_start;
            end else begin
                r_start <= i_cfg_data[WIN_AW-1:0];
                r_wpos  <= i_cfg_data[WIN_AW-1:0];
            end
            r_cnt      <= '0;
            r_phase    <= PH_FLAG;
            r_flags    <= '0;
            r_fidx     <= '0;
            r_low      <= '0;
            r_rst_pend <= 1'b0;
            r_rem      <= '0;
            r_p1_valid <= 1'b0;
            if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end else begin
            r_phase <= n_phase;
            r_flags <= n_flags;
            r_fidx  <= n_fidx;
            r_low   <= n_low;

            // Stream end waits for the last byte to reach the window
            if (drain_done) begin
                r_rst_pend <= 1'b0;
            end else if (in_acc && i_in.in_last) begin
                r_rst_pend <= 1'b1;
            end

            // Write position and fill count
            if (drain_done) begin
                r_wpos <= r_start;
                r_cnt  <= '0;
            end else if (wr_en) begin
                r_wpos <= r_wpos + 1'b1;
                if (!r_cnt[CNT_W-1]) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end

            // Copy counter
            if (dec_mhigh) begin
                r_rem <= LEN_W'(MIN_MATCH) + LEN_W'(i_in.in_byte[3:0]);
            end else if (issue) begin
                r_rem <= r_rem - 1'b1;
            end

            // Write stage occupancy
            if (issue || dec_lit) begin
                r_p1_valid <= 1'b1;
            end else if (wr_en) begin
                r_p1_valid <= 1'b0;
            end

            // Output register occupancy
            if (wr_en) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers and window RAM
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_wpos] <= wr_byte;
            r_out       <= '{out_byte: wr_byte, out_last: r_p1_last};
        end
        if (issue) begin
            r_mem_q <= mem[r_src];
        end
        if (dec_mhigh) begin
            r_src <= {i_in.in_byte[7:4], r_low};
        end else if (issue) begin
            r_src <= r_src + 1'b1;
        end
        // Forwarded, unwritten and literal bytes bypass the RAM
        if (issue) begin
            r_p1_mem  <= hit && !fwd;
            r_p1_data <= fwd ? wr_byte : r_fill;
            r_p1_last <= (r_rem == LEN_W'(1));
        end else if (dec_lit) begin
            r_p1_mem  <= 1'b0;
            r_p1_data <= i_in.in_byte;
            r_p1_last <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Checks
    `LZD_ASSERT(a_stall_holds, i_clk, i_rst_n, (r_p1_valid && !out_ok && !i_cfg_we) |=> (r_p1_valid && $stable(r_wpos)), "write stage lost a byte during output stall")
    `LZD_ASSERT(a_issue_fills, i_clk, i_rst_n, (issue && !i_cfg_we) |=> r_p1_valid, "window read issued without a write stage entry")
    `LZD_ASSERT(a_match_len, i_clk, i_rst_n, (dec_mhigh && !i_cfg_we) |=> (r_rem >= LEN_W'(MIN_MATCH)), "match started with short length")
    `LZD_ASSERT_ALWAYS(a_cnt_range, i_clk, (!i_rst_n || !r_cnt[CNT_W-1] || (r_cnt[WIN_AW-1:0] == '0)), "fill count beyond window size")

endmodule

`default_nettype wire
